FILE: hdl/dsts_pkg.sv
package dsts_pkg;

  localparam int unsigned ValW     = 63;
  localparam int unsigned NumUnits = 5;
  localparam int unsigned WeightW  = 25;
  localparam int unsigned WideW    = ValW + 5;
  localparam int unsigned ProdW    = WeightW + 4;

  typedef logic [ValW-1:0]    val_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [2:0]         unit_idx_t;

  localparam val_t MaxVal = '1;

  // Unit and digit characters in ASCII.
  localparam logic [7:0] CharS    = 8'h73;
  localparam logic [7:0] CharM    = 8'h6d;
  localparam logic [7:0] CharH    = 8'h68;
  localparam logic [7:0] CharD    = 8'h64;
  localparam logic [7:0] CharY    = 8'h79;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam unit_idx_t UnitSec  = 3'd0;
  localparam unit_idx_t UnitMin  = 3'd1;
  localparam unit_idx_t UnitHour = 3'd2;
  localparam unit_idx_t UnitDay  = 3'd3;
  localparam unit_idx_t UnitYear = 3'd4;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrFormat = 2'd1,
    ErrUnit   = 2'd2,
    ErrOvf    = 2'd3
  } err_e;

  // One scaled accumulator: the current number times one unit weight.
  typedef struct packed {
    val_t scaled;
    logic big;
  } lane_t;

  typedef struct packed {
    logic      known;
    unit_idx_t idx;
  } unit_sel_t;

  function automatic weight_t unit_weight(unit_idx_t idx);
    weight_t w;
    unique case (idx)
      UnitSec:  w = weight_t'(1);
      UnitMin:  w = weight_t'(60);
      UnitHour: w = weight_t'(3600);
      UnitDay:  w = weight_t'(86400);
      UnitYear: w = weight_t'(31536000);
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic unit_sel_t unit_lookup(logic [7:0] c);
    unit_sel_t s;
    s.known = 1'b1;
    unique case (c)
      CharS:   s.idx = UnitSec;
      CharM:   s.idx = UnitMin;
      CharH:   s.idx = UnitHour;
      CharD:   s.idx = UnitDay;
      CharY:   s.idx = UnitYear;
      default: begin
        s.known = 1'b0;
        s.idx   = UnitSec;
      end
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/dsts_if.sv
interface dsts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface dsts_out_if;
  logic                valid;
  logic                ready;
  dsts_pkg::val_t      seconds;
  logic [1:0]          error;

  modport source (output valid, output seconds, output error, input ready);
  modport sink (input valid, input seconds, input error, output ready);
endinterface

FILE: hdl/dsts_lane.sv
module dsts_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  clear_i,
  input  logic                  digit_i,
  input  logic                  drop_i,
  input  logic [3:0]            digit_val_i,
  input  dsts_pkg::weight_t     weight_i,
  output dsts_pkg::lane_t       lane_o,
  output logic                  ovf_o
);

  dsts_pkg::lane_t                  lane_q, lane_d;
  dsts_pkg::val_t                   base;
  logic                             base_big;
  logic [dsts_pkg::ProdW-1:0]       digit_prod;
  logic [dsts_pkg::WideW-1:0]       wide;

  // A new number starts when a digit follows a unit, so the old value is dropped.
  assign base       = drop_i ? '0 : lane_q.scaled;
  assign base_big   = drop_i ? 1'b0 : lane_q.big;
  assign digit_prod = dsts_pkg::ProdW'(digit_val_i) * dsts_pkg::ProdW'(weight_i);
  assign wide       = (dsts_pkg::WideW'(base) << 3) + (dsts_pkg::WideW'(base) << 1)
                    + dsts_pkg::WideW'(digit_prod);
  assign ovf_o      = base_big | (|wide[dsts_pkg::WideW-1:dsts_pkg::ValW]);

  always_comb begin
    lane_d = lane_q;
    if (clear_i) begin
      lane_d = '0;
    end else if (digit_i) begin
      lane_d.scaled = wide[dsts_pkg::ValW-1:0];
      lane_d.big    = ovf_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: hdl/dsts_commit.sv
module dsts_commit (
  input  dsts_pkg::lane_t [dsts_pkg::NumUnits-1:0] lanes_i,
  input  dsts_pkg::val_t                           total_i,
  input  dsts_pkg::err_e                           err_i,
  input  logic [7:0]                               unit_char_i,
  input  logic                                     unit_ok_i,
  output dsts_pkg::val_t                           total_o,
  output dsts_pkg::err_e                           err_o
);

  dsts_pkg::unit_sel_t sel;
  dsts_pkg::lane_t     picked;
  logic [dsts_pkg::ValW:0] sum;

  assign sel    = dsts_pkg::unit_lookup(unit_char_i);
  assign picked = lanes_i[sel.idx];
  assign sum    = {1'b0, total_i} + {1'b0, picked.scaled};

  // The pair adds to the total only if no error is pending yet.
  always_comb begin
    total_o = total_i;
    err_o   = err_i;
    priority if (err_i != dsts_pkg::ErrNone) begin
      err_o = err_i;
    end else if (!unit_ok_i || !sel.known) begin
      err_o = dsts_pkg::ErrUnit;
    end else if (picked.big || sum[dsts_pkg::ValW]) begin
      err_o = dsts_pkg::ErrOvf;
    end else begin
      total_o = sum[dsts_pkg::ValW-1:0];
    end
  end

endmodule

FILE: hdl/duration_string_to_seconds.sv
// Duration string to seconds converter.
// Bytes of a string such as "1d2h30m" arrive on in_i, one word per cycle
// while in_i is ready, with last marking the final byte. For each string
// exactly one word leaves on out_o, taken from the final byte: the total in
// seconds and an error code (0 ok, 1 malformed, 2 unknown unit, 3 overflow);
// seconds is zero on error. Units are s, m, h, d and y. Values never wrap:
// overflow is reported instead. A byte taken from in_i waits in the input
// register; when it moves on, its effect reaches the string state and, for a
// final byte, the output register, which then offers the result.
// Throughput: one byte per cycle across string boundaries while out_o is ready.
// The rate is set by the single update of the number and total registers;
// every unit weight keeps its own scaled copy of the current number, so a
// pair is committed with one add and compare.
// When out_o stalls, the held result stays put; bytes that are not final keep
// flowing, and a second final byte waits in the input register until the
// output register frees up.
// Reset clears the string state, the input stage and the output valid.
module duration_string_to_seconds (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsts_in_if.sink    in_i,
  dsts_out_if.source out_o
);

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_ch_q;
  logic       s1_last_q;
  logic       advance;
  logic       in_take;

  // String state.
  logic           digits_seen_q, digits_seen_d;
  logic           in_unit_q, in_unit_d;
  logic [7:0]     unit_char_q, unit_char_d;
  logic [1:0]     unit_len_q, unit_len_d;
  dsts_pkg::val_t total_q, total_d;
  dsts_pkg::err_e pend_q, pend_d;

  // Output register.
  logic           out_valid_q, out_valid_d;
  dsts_pkg::val_t seconds_q, seconds_d;
  dsts_pkg::err_e error_q, error_d;

  logic       is_digit;
  logic [3:0] digit_val;

  dsts_pkg::lane_t [dsts_pkg::NumUnits-1:0] lanes;
  logic [dsts_pkg::NumUnits-1:0]            lane_ovf;

  // Commit port.
  dsts_pkg::err_e cm_err_in, cm_err;
  dsts_pkg::val_t cm_total;
  logic [7:0]     cm_char;
  logic           cm_ok;
  dsts_pkg::err_e pend_mid;

  // A byte that is not final always moves on. A final byte needs the output
  // register to be empty or being emptied in this cycle.
  assign advance  = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  assign is_digit  = (s1_ch_q >= dsts_pkg::CharZero) && (s1_ch_q <= dsts_pkg::CharNine);
  assign digit_val = s1_ch_q[3:0];

  for (genvar g = 0; g < dsts_pkg::NumUnits; g++) begin : g_lane
    dsts_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (advance),
      .clear_i     (s1_last_q),
      .digit_i     (is_digit),
      .drop_i      (in_unit_q),
      .digit_val_i (digit_val),
      .weight_i    (dsts_pkg::unit_weight(dsts_pkg::unit_idx_t'(g))),
      .lane_o      (lanes[g]),
      .ovf_o       (lane_ovf[g])
    );
  end

  // A pair is committed either at a digit that follows a unit, or at a final
  // byte that opens a one-character unit. In the second case a leading
  // non-digit has to be flagged before the commit sees the pending error.
  always_comb begin
    if (is_digit) begin
      cm_err_in = pend_q;
      cm_char   = unit_char_q;
      cm_ok     = (unit_len_q == 2'd1);
    end else begin
      cm_err_in = digits_seen_q ? pend_q : dsts_pkg::ErrFormat;
      cm_char   = s1_ch_q;
      cm_ok     = 1'b1;
    end
  end

  dsts_commit u_commit (
    .lanes_i     (lanes),
    .total_i     (total_q),
    .err_i       (cm_err_in),
    .unit_char_i (cm_char),
    .unit_ok_i   (cm_ok),
    .total_o     (cm_total),
    .err_o       (cm_err)
  );

  assign pend_mid = in_unit_q ? cm_err : pend_q;

  always_comb begin
    digits_seen_d = digits_seen_q;
    in_unit_d     = in_unit_q;
    unit_char_d   = unit_char_q;
    unit_len_d    = unit_len_q;
    total_d       = total_q;
    pend_d        = pend_q;
    seconds_d     = seconds_q;
    error_d       = error_q;

    if (s1_last_q) begin
      // A string must end in a single-character unit that this byte opens.
      if (!is_digit && !in_unit_q) begin
        error_d = cm_err;
      end else begin
        error_d = dsts_pkg::ErrFormat;
      end
      seconds_d     = (error_d == dsts_pkg::ErrNone) ? cm_total : '0;
      digits_seen_d = 1'b0;
      in_unit_d     = 1'b0;
      unit_char_d   = '0;
      unit_len_d    = '0;
      total_d       = '0;
      pend_d        = dsts_pkg::ErrNone;
    end else if (is_digit) begin
      if (in_unit_q) begin
        total_d = cm_total;
      end
      // The lane for seconds holds the plain number, so its overflow is the
      // overflow of the number itself.
      pend_d        = (pend_mid == dsts_pkg::ErrNone && lane_ovf[dsts_pkg::UnitSec])
                    ? dsts_pkg::ErrOvf : pend_mid;
      digits_seen_d = 1'b1;
      in_unit_d     = 1'b0;
      unit_char_d   = '0;
      unit_len_d    = '0;
    end else if (!in_unit_q) begin
      if (!digits_seen_q) begin
        pend_d = dsts_pkg::ErrFormat;
      end
      in_unit_d   = 1'b1;
      unit_char_d = s1_ch_q;
      unit_len_d  = 2'd1;
    end else if (unit_len_q != 2'd2) begin
      unit_len_d = unit_len_q + 2'd1;
    end
  end

  always_comb begin
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (advance && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      digits_seen_q <= 1'b0;
      in_unit_q     <= 1'b0;
      unit_char_q   <= '0;
      unit_len_q    <= '0;
      total_q       <= '0;
      pend_q        <= dsts_pkg::ErrNone;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        digits_seen_q <= digits_seen_d;
        in_unit_q     <= in_unit_d;
        unit_char_q   <= unit_char_d;
        unit_len_q    <= unit_len_d;
        total_q       <= total_d;
        pend_q        <= pend_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.last;
    end
    if (advance && s1_last_q) begin
      seconds_q <= seconds_d;
      error_q   <= error_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.seconds = seconds_q;
  assign out_o.error   = error_q;

`ifndef SYNTHESIS
  // A reported error never comes with a nonzero total.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && error_q != dsts_pkg::ErrNone) |-> (seconds_q == '0))
    else $error("nonzero seconds with an error");

  // The unit flag and the unit length agree.
  a_unit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_unit_q == (unit_len_q == 2'd1 || unit_len_q == 2'd2))
    else $error("unit flag and unit length disagree");

  // After a final byte the string state is clear again.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=>
      (!in_unit_q && !digits_seen_q && total_q == '0 && pend_q == dsts_pkg::ErrNone))
    else $error("string state not cleared after final byte");
`endif

endmodule
